[src/cbsf_pkg.sv]
// ----------------------------------------------------------------------------
// cbsf_pkg
// Types and constants shared by the cluster bounding box size filter.
// ----------------------------------------------------------------------------
package cbsf_pkg;

  localparam int COORD_W    = 20;
  localparam int COUNT_W    = 16;
  localparam int POINTS_W   = 16;
  localparam int DIAG_W     = 21;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 21;

  localparam int SQ_W      = 2 * COORD_W;
  localparam int SUM_W     = SQ_W + 2;
  localparam int LIM_SQ_W  = 2 * DIAG_W;
  localparam int CMP_W     = (SUM_W > LIM_SQ_W) ? SUM_W : LIM_SQ_W;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_POINTS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_POINTS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DIAGONAL = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DIAGONAL = 2'd3;

  localparam logic [POINTS_W-1:0] MIN_POINTS_RST   = 16'd1;
  localparam logic [POINTS_W-1:0] MAX_POINTS_RST   = 16'hFFFF;
  localparam logic [DIAG_W-1:0]   MIN_DIAGONAL_RST = 21'd0;
  localparam logic [DIAG_W-1:0]   MAX_DIAGONAL_RST = 21'h1FFFFF;

  typedef struct packed {
    logic signed [COORD_W-1:0] x_coord;
    logic signed [COORD_W-1:0] y_coord;
    logic signed [COORD_W-1:0] z_coord;
    logic                      last_point;
  } point_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] box_min_x;
    logic signed [COORD_W-1:0] box_min_y;
    logic signed [COORD_W-1:0] box_min_z;
    logic signed [COORD_W-1:0] box_max_x;
    logic signed [COORD_W-1:0] box_max_y;
    logic signed [COORD_W-1:0] box_max_z;
    logic [COUNT_W-1:0]        point_count;
    logic                      keep_cluster;
  } result_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] min_x;
    logic signed [COORD_W-1:0] min_y;
    logic signed [COORD_W-1:0] min_z;
    logic signed [COORD_W-1:0] max_x;
    logic signed [COORD_W-1:0] max_y;
    logic signed [COORD_W-1:0] max_z;
    logic [COUNT_W-1:0]        count;
  } box_rec_t;

  typedef struct packed {
    logic                  wen;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

endpackage

[src/cbsf_fifo.sv]
// ----------------------------------------------------------------------------
// cbsf_fifo
// Small register based queue, first word fall through.
// ----------------------------------------------------------------------------
module cbsf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == (AW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[src/cbsf_front.sv]
// ----------------------------------------------------------------------------
// cbsf_front
// Running box and saturating count; hands a finished cluster to the queue.
// ----------------------------------------------------------------------------
module cbsf_front
  import cbsf_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  point_t   point,
  output logic     full,
  input  logic     q_full,
  output logic     q_push,
  output box_rec_t q_data
);

  logic                      mid_cluster;
  logic signed [COORD_W-1:0] run_min_x, run_min_y, run_min_z;
  logic signed [COORD_W-1:0] run_max_x, run_max_y, run_max_z;
  logic [COUNT_W-1:0]        run_count;
  box_rec_t                  box_next;
  logic                      accept;

  assign full   = q_full;
  assign accept = push && !q_full;

  always_comb begin
    if (!mid_cluster) begin
      box_next.min_x = point.x_coord;
      box_next.min_y = point.y_coord;
      box_next.min_z = point.z_coord;
      box_next.max_x = point.x_coord;
      box_next.max_y = point.y_coord;
      box_next.max_z = point.z_coord;
      box_next.count = COUNT_W'(1);
    end else begin
      box_next.min_x = (point.x_coord < run_min_x) ? point.x_coord : run_min_x;
      box_next.min_y = (point.y_coord < run_min_y) ? point.y_coord : run_min_y;
      box_next.min_z = (point.z_coord < run_min_z) ? point.z_coord : run_min_z;
      box_next.max_x = (point.x_coord > run_max_x) ? point.x_coord : run_max_x;
      box_next.max_y = (point.y_coord > run_max_y) ? point.y_coord : run_max_y;
      box_next.max_z = (point.z_coord > run_max_z) ? point.z_coord : run_max_z;
      box_next.count = (run_count == COUNT_MAX) ? run_count : run_count + 1'b1;
    end
  end

  assign q_push = accept && point.last_point;
  assign q_data = box_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_cluster <= 1'b0;
    end else if (accept) begin
      mid_cluster <= !point.last_point;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      run_min_x <= box_next.min_x;
      run_min_y <= box_next.min_y;
      run_min_z <= box_next.min_z;
      run_max_x <= box_next.max_x;
      run_max_y <= box_next.max_y;
      run_max_z <= box_next.max_z;
      run_count <= box_next.count;
    end
  end

endmodule

[src/cbsf_back.sv]
// ----------------------------------------------------------------------------
// cbsf_back
// Limit registers, keep test pipeline (span, square, sum, compare) and the
// result queue.
// ----------------------------------------------------------------------------
module cbsf_back
  import cbsf_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  cfg_wr_t  cfg,
  input  logic     q_empty,
  input  box_rec_t q_data,
  output logic     q_pop,
  output result_t  result,
  output logic     empty,
  input  logic     pop
);

  localparam int RES_W = $bits(result_t);

  logic [POINTS_W-1:0] min_points, max_points;
  logic [DIAG_W-1:0]   min_diagonal, max_diagonal;
  logic [LIM_SQ_W-1:0] min_sq, max_sq;

  logic               en;
  logic               out_full;
  logic               s1_valid, s2_valid, s3_valid;
  box_rec_t           s1_rec, s2_rec, s3_rec;
  logic               s1_size_ok, s2_size_ok, s3_size_ok;
  logic [COORD_W-1:0] s1_dx, s1_dy, s1_dz;
  logic [SQ_W-1:0]    s2_sqx, s2_sqy, s2_sqz;
  logic [SUM_W-1:0]   s3_sum;
  logic [CMP_W-1:0]   sum_cmp, min_cmp, max_cmp;
  result_t            res_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_points   <= MIN_POINTS_RST;
      max_points   <= MAX_POINTS_RST;
      min_diagonal <= MIN_DIAGONAL_RST;
      max_diagonal <= MAX_DIAGONAL_RST;
    end else if (cfg.wen) begin
      case (cfg.index)
        REG_MIN_POINTS:   min_points   <= cfg.data[POINTS_W-1:0];
        REG_MAX_POINTS:   max_points   <= cfg.data[POINTS_W-1:0];
        REG_MIN_DIAGONAL: min_diagonal <= cfg.data[DIAG_W-1:0];
        REG_MAX_DIAGONAL: max_diagonal <= cfg.data[DIAG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    min_sq <= min_diagonal * min_diagonal;
    max_sq <= max_diagonal * max_diagonal;
  end

  assign en    = !s3_valid || !out_full;
  assign q_pop = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= !q_empty;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_rec     <= q_data;
      s1_dx      <= q_data.max_x - q_data.min_x;
      s1_dy      <= q_data.max_y - q_data.min_y;
      s1_dz      <= q_data.max_z - q_data.min_z;
      s1_size_ok <= (q_data.count >= min_points) && (q_data.count <= max_points);

      s2_rec     <= s1_rec;
      s2_size_ok <= s1_size_ok;
      s2_sqx     <= s1_dx * s1_dx;
      s2_sqy     <= s1_dy * s1_dy;
      s2_sqz     <= s1_dz * s1_dz;

      s3_rec     <= s2_rec;
      s3_size_ok <= s2_size_ok;
      s3_sum     <= SUM_W'(s2_sqx) + SUM_W'(s2_sqy) + SUM_W'(s2_sqz);
    end
  end

  assign sum_cmp = CMP_W'(s3_sum);
  assign min_cmp = CMP_W'(min_sq);
  assign max_cmp = CMP_W'(max_sq);

  always_comb begin
    res_in.box_min_x    = s3_rec.min_x;
    res_in.box_min_y    = s3_rec.min_y;
    res_in.box_min_z    = s3_rec.min_z;
    res_in.box_max_x    = s3_rec.max_x;
    res_in.box_max_y    = s3_rec.max_y;
    res_in.box_max_z    = s3_rec.max_z;
    res_in.point_count  = s3_rec.count;
    res_in.keep_cluster = s3_size_ok && (sum_cmp >= min_cmp) && (sum_cmp <= max_cmp);
  end

  cbsf_fifo #(
    .WIDTH (RES_W),
    .DEPTH (2)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (s3_valid),
    .din   (res_in),
    .full  (out_full),
    .pop   (pop),
    .dout  (result),
    .empty (empty)
  );

endmodule

[src/cluster_bbox_size_filter.sv]
// ----------------------------------------------------------------------------
// cluster_bbox_size_filter
// Axis-aligned bounding box of a point cluster with a size and extent filter.
// ----------------------------------------------------------------------------
// Takes one point per clock, back to back, for as long as the cluster queue
// has room; the running min/max compare-and-select in the front accumulator
// is the per-point loop. A cluster's box, count and keep flag reach the
// result side after its last point is taken and passes the cluster queue
// and the span, square and sum registers; the limit compare sits ahead of
// the result queue. The cluster queue holds four clusters, the output two.
// The keep flag needs min_points <= count <= max_points and
// min_diagonal^2 <= dx^2 + dy^2 + dz^2 <= max_diagonal^2.
module cluster_bbox_size_filter
  import cbsf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  point_t                point,
  output logic                  full,
  output result_t               result,
  output logic                  empty,
  input  logic                  pop,
  input  logic                  cfg_wen,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int REC_W   = $bits(box_rec_t);
  localparam int Q_DEPTH = 4;

  logic     q_full, q_push, q_empty, q_pop;
  box_rec_t q_din, q_dout;
  cfg_wr_t  cfg;

  assign cfg.wen   = cfg_wen;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  cbsf_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .point  (point),
    .full   (full),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_din)
  );

  cbsf_fifo #(
    .WIDTH (REC_W),
    .DEPTH (Q_DEPTH)
  ) u_box_q (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  cbsf_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_empty (q_empty),
    .q_data  (q_dout),
    .q_pop   (q_pop),
    .result  (result),
    .empty   (empty),
    .pop     (pop)
  );

endmodule

[src/cbsf_checker.sv]
// ----------------------------------------------------------------------------
// cbsf_checker
// Port level checks for the cluster bounding box size filter.
// ----------------------------------------------------------------------------
module cbsf_checker
  import cbsf_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    push,
  input point_t  point,
  input logic    full,
  input result_t result,
  input logic    empty,
  input logic    pop
);

  // clusters closed but not yet popped
  logic [7:0] pending;
  logic       closed;
  logic       taken;

  assign closed = push && !full && point.last_point;
  assign taken  = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      case ({closed, taken})
        2'b10:   pending <= pending + 1'b1;
        2'b01:   pending <= pending - 1'b1;
        default: pending <= pending;
      endcase
    end
  end

  a_no_result_without_cluster: assert property (@(posedge clk) disable iff (rst)
    !empty |-> pending != '0)
    else $error("result transaction without a closed cluster");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(result))
    else $error("waiting result changed");

  a_box_ordered: assert property (@(posedge clk) disable iff (rst)
    !empty |-> result.box_min_x <= result.box_max_x &&
               result.box_min_y <= result.box_max_y &&
               result.box_min_z <= result.box_max_z)
    else $error("box min above max");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    !empty |-> result.point_count != '0)
    else $error("cluster with zero points");

endmodule

bind cluster_bbox_size_filter cbsf_checker u_checker (.*);
